FILE: src/krt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

	localparam int ENTRIES_DEF = 128;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] age;
		logic [31:0] marks;
	} rec_t;

	typedef struct packed {
		logic rotate;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: src/krt_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface krt_cmd_if;
	logic               valid;
	logic               ready;
	krt_pkg::cmd_t      cmd;
	logic signed [31:0] key;
	logic signed [31:0] age_in;
	logic        [31:0] marks_in;

	modport source (output valid, cmd, key, age_in, marks_in, input ready);
	modport sink (input valid, cmd, key, age_in, marks_in, output ready);
endinterface

`default_nettype wire

FILE: src/krt_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface krt_res_if;
	logic               valid;
	logic               ready;
	krt_pkg::status_t   status;
	logic        [6:0]  slot;
	logic signed [31:0] age_out;
	logic        [31:0] marks_out;
	logic        [7:0]  used;

	modport source (output valid, status, slot, age_out, marks_out, used, input ready);
	modport sink (input valid, status, slot, age_out, marks_out, used, output ready);
endinterface

`default_nettype wire

FILE: src/krt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the table. It takes the record of its right-hand neighbour when the
// ring rotates, or when a delete closes the gap at or below this slot.
module krt_cell #(
	parameter int IW  = 7,
	parameter int IDX = 0
) (
	input  wire logic               clk,
	input  wire krt_pkg::cell_ctl_t ctl,
	input  wire logic [IW-1:0]      hit,
	input  wire krt_pkg::rec_t      next_rec,
	output krt_pkg::rec_t           rec
);

	krt_pkg::rec_t rec_q;
	logic          take;

	assign take = ctl.rotate || (ctl.shift && (IW'(IDX) >= hit));
	assign rec  = rec_q;

	always_ff @(posedge clk) begin
		if (take) begin
			rec_q <= next_rec;
		end
	end

endmodule

`default_nettype wire

FILE: src/keyed_record_table_top.sv
`timescale 1ns / 1ps
// Keyed record table: up to ENTRIES records (32-bit key, age and marks) held packed
// in insertion order in a ring of cells. Each command rotates the ring once round,
// so that every slot passes the head cell, where the key is compared and the record
// is read, overwritten or appended; a delete then moves the later records down by
// one slot in the FINISH state. A command passes through SCAN, one step per slot of
// the ring, then FINISH, which waits until the result register is free; the next
// command is then taken back in IDLE, even while the result beat still waits.
`default_nettype none

module keyed_record_table_top #(
	parameter int ENTRIES = krt_pkg::ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	krt_cmd_if.sink  req,
	krt_res_if.source rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

	state_t             state_q;
	krt_pkg::cmd_t      cmd_q;
	logic [31:0]        key_q;
	logic [31:0]        age_q;
	logic [31:0]        marks_q;
	logic [IW-1:0]      t_q;
	logic               found_q;
	logic [IW-1:0]      hit_q;
	logic [31:0]        lk_age_q;
	logic [31:0]        lk_marks_q;
	logic [CW-1:0]      fill_q;

	logic               rsp_valid_q;
	krt_pkg::status_t   status_q;
	logic [6:0]         slot_q;
	logic [31:0]        age_out_q;
	logic [31:0]        marks_out_q;
	logic [7:0]         used_q;

	krt_pkg::status_t   status_d;
	logic [6:0]         slot_d;
	logic [31:0]        age_out_d;
	logic [31:0]        marks_out_d;
	logic [CW-1:0]      fill_d;

	krt_pkg::rec_t      rec [ENTRIES];
	krt_pkg::rec_t      wrap;
	krt_pkg::cell_ctl_t ctl;
	logic               occ;
	logic               match;
	logic               full;
	logic               out_free;
	logic               accept;

	assign req.ready     = (state_q == IDLE);
	assign accept        = req.valid && req.ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.slot      = slot_q;
	assign rsp.age_out   = age_out_q;
	assign rsp.marks_out = marks_out_q;
	assign rsp.used      = used_q;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign full     = (fill_q == CW'(ENTRIES));
	assign occ      = (CW'(t_q) < fill_q);
	assign match    = (state_q == SCAN) && occ && !found_q && (rec[0].key == key_q);

	assign ctl.rotate = (state_q == SCAN);
	assign ctl.shift  = (state_q == FINISH) && out_free
		&& (cmd_q == krt_pkg::CMD_DELETE) && found_q;

	always_comb begin
		wrap = rec[0];
		if (cmd_q == krt_pkg::CMD_UPDATE && match) begin
			wrap.age   = age_q;
			wrap.marks = marks_q;
		end
		if (cmd_q == krt_pkg::CMD_INSERT && !found_q && CW'(t_q) == fill_q) begin
			wrap.key   = key_q;
			wrap.age   = age_q;
			wrap.marks = marks_q;
		end
	end

	always_comb begin
		status_d    = krt_pkg::ST_OK;
		slot_d      = '0;
		age_out_d   = '0;
		marks_out_d = '0;
		fill_d      = fill_q;
		if (cmd_q == krt_pkg::CMD_INSERT) begin
			if (full) begin
				status_d = krt_pkg::ST_FULL;
			end else if (found_q) begin
				status_d = krt_pkg::ST_DUPLICATE;
			end else begin
				slot_d = 7'(fill_q);
				fill_d = fill_q + 1'b1;
			end
		end else if (!found_q) begin
			status_d = krt_pkg::ST_NOT_FOUND;
		end else begin
			slot_d = 7'(hit_q);
			if (cmd_q == krt_pkg::CMD_LOOKUP) begin
				age_out_d   = lk_age_q;
				marks_out_d = lk_marks_q;
			end
			if (cmd_q == krt_pkg::CMD_DELETE) begin
				fill_d = fill_q - 1'b1;
			end
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		krt_pkg::rec_t next_rec;

		if (i == ENTRIES - 1) begin : g_last
			assign next_rec = wrap;
		end else begin : g_mid
			assign next_rec = rec[i + 1];
		end

		krt_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.hit      (hit_q),
			.next_rec (next_rec),
			.rec      (rec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cmd_q       <= krt_pkg::CMD_INSERT;
			key_q       <= '0;
			age_q       <= '0;
			marks_q     <= '0;
			t_q         <= '0;
			found_q     <= 1'b0;
			hit_q       <= '0;
			lk_age_q    <= '0;
			lk_marks_q  <= '0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= krt_pkg::ST_OK;
			slot_q      <= '0;
			age_out_q   <= '0;
			marks_out_q <= '0;
			used_q      <= '0;
		end else begin
			if (state_q == FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						cmd_q   <= req.cmd;
						key_q   <= req.key;
						age_q   <= req.age_in;
						marks_q <= req.marks_in;
						t_q     <= '0;
						found_q <= 1'b0;
						hit_q   <= '0;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (match) begin
						found_q    <= 1'b1;
						hit_q      <= t_q;
						lk_age_q   <= rec[0].age;
						lk_marks_q <= rec[0].marks;
					end
					if (t_q == IW'(ENTRIES - 1)) begin
						state_q <= FINISH;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				FINISH: begin
					if (out_free) begin
						status_q    <= status_d;
						slot_q      <= slot_d;
						age_out_q   <= age_out_d;
						marks_out_q <= marks_out_d;
						fill_q      <= fill_d;
						used_q      <= 8'(fill_d);
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
